FILE: src/voxel_chunk_face_culler_macros.svh
// Assertion macros shared by the face culler modules.
`ifndef VOXEL_CHUNK_FACE_CULLER_MACROS_SVH
`define VOXEL_CHUNK_FACE_CULLER_MACROS_SVH

// Checked on every clock edge outside reset.
`define VCFC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define VCFC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: src/vcfc_pkg.sv
// Shared types, codes and constants of the voxel chunk face culler.
`timescale 1ns / 1ps
`default_nettype none

package vcfc_pkg;

  localparam int unsigned MAX_EDGE_DEF = 16;
  localparam int unsigned NUM_DIRS     = 6;
  localparam int unsigned DIR_W        = 3;
  localparam int unsigned COORD_W      = 4;
  localparam int unsigned CLASS_W      = 2;
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned EDGE_W       = 6;
  localparam int unsigned CHUNK_EDGE_W = 5;
  localparam int unsigned MASK_W       = 6;
  localparam int unsigned FACE_W       = 15;
  localparam int unsigned TOTAL_W      = 3;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 6;

  localparam logic [FACE_W-1:0]       FACE_CAP       = 15'd24576;
  localparam logic [CHUNK_EDGE_W-1:0] CHUNK_EDGE_RST = 5'd16;

  localparam logic [REQ_W-1:0] REQ_WR_OWN  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WR_NB   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_EDGE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_PRESENT = 2'd1;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
    logic [DIR_W-1:0]   side;
    logic [CLASS_W-1:0] cell_class;
  } req_t;

  typedef struct packed {
    logic [MASK_W-1:0]  face_mask;
    logic [FACE_W-1:0]  face_base;
    logic [TOTAL_W-1:0] face_total;
  } res_t;

  typedef struct packed {
    logic             capture;
    logic             clear;
    logic             exec;
    logic             rd_center;
    logic             rd_dir;
    logic             finish;
    logic [DIR_W-1:0] dir;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/vcfc_ctrl.sv
// Controller state machine sequencing clears, writes and query reads.
`timescale 1ns / 1ps
`default_nettype none

module vcfc_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [vcfc_pkg::REQ_W-1:0] req_type_i,
  input  wire vcfc_pkg::sts_t             sts_i,
  output vcfc_pkg::cmd_t                  cmd_o,
  output logic                            busy_o
);

  `include "voxel_chunk_face_culler_macros.svh"

  localparam int unsigned DirW = vcfc_pkg::DIR_W;
  localparam logic [DirW-1:0] DirLast = DirW'(vcfc_pkg::NUM_DIRS - 1);
  localparam logic [DirW-1:0] DirNum  = DirW'(vcfc_pkg::NUM_DIRS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_RD_C  = 3'd3;
  localparam logic [2:0] ST_RD_D  = 3'd4;
  localparam logic [2:0] ST_LAST  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [DirW-1:0] dir_q, dir_d;
  logic            accept;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    dir_d   = dir_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = (req_type_i == vcfc_pkg::REQ_QUERY) ? ST_RD_C : ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      ST_RD_C: begin
        state_d = ST_RD_D;
        dir_d   = '0;
      end
      ST_RD_D: begin
        if (dir_q == DirLast) begin
          state_d = ST_LAST;
        end else begin
          dir_d = dir_q + 1'b1;
        end
      end
      ST_LAST: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      dir_q   <= '0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
    end
  end

  always_comb begin
    cmd_o.capture   = accept;
    cmd_o.clear     = (state_q == ST_CLEAR);
    cmd_o.exec      = (state_q == ST_EXEC);
    cmd_o.rd_center = (state_q == ST_RD_C);
    cmd_o.rd_dir    = (state_q == ST_RD_D);
    cmd_o.finish    = (state_q == ST_LAST);
    cmd_o.dir       = dir_q;
  end

  `VCFC_ASSERT(a_accept_busy, accept |=> busy_o, "accepted word did not make the block busy")
  `VCFC_ASSERT(a_dir_range, (state_q == ST_RD_D) |-> (dir_q < DirNum), "direction out of range")

endmodule

`default_nettype wire

FILE: src/vcfc_datapath.sv
// Datapath with cell and layer stores, configuration, face evaluation and counter.
`timescale 1ns / 1ps
`default_nettype none

module vcfc_datapath #(
  parameter int unsigned MAX_EDGE = vcfc_pkg::MAX_EDGE_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic [vcfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [vcfc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire vcfc_pkg::req_t                  req_i,
  input  wire vcfc_pkg::cmd_t                  cmd_i,
  output vcfc_pkg::sts_t                       sts_o,
  output logic                                 res_valid_o,
  output vcfc_pkg::res_t                       res_o
);

  `include "voxel_chunk_face_culler_macros.svh"

  localparam int unsigned EdgeW  = vcfc_pkg::EDGE_W;
  localparam int unsigned DirW   = vcfc_pkg::DIR_W;
  localparam int unsigned FaceW  = vcfc_pkg::FACE_W;
  localparam int unsigned TotalW = vcfc_pkg::TOTAL_W;
  localparam int unsigned MaskW  = vcfc_pkg::MASK_W;
  localparam int unsigned ClassW = vcfc_pkg::CLASS_W;
  localparam int unsigned CeW    = vcfc_pkg::CHUNK_EDGE_W;

  localparam int unsigned CW        = $clog2(MAX_EDGE);
  localparam int unsigned CellAW    = 3 * CW;
  localparam int unsigned CellDepth = 1 << CellAW;
  localparam int unsigned LayAW     = DirW + 2 * CW;
  localparam int unsigned LayDepth  = vcfc_pkg::NUM_DIRS << (2 * CW);
  localparam int unsigned ClrDepth  = (CellDepth > LayDepth) ? CellDepth : LayDepth;
  localparam int unsigned ClrW      = $clog2(ClrDepth);

  typedef logic [ClrW:0] clr_ext_t;

  localparam clr_ext_t           CellDepthL = clr_ext_t'(CellDepth);
  localparam clr_ext_t           LayDepthL  = clr_ext_t'(LayDepth);
  localparam logic [ClrW-1:0]    ClrLastL   = ClrW'(ClrDepth - 1);
  localparam logic [EdgeW-1:0]   MaxEdgeL   = EdgeW'(MAX_EDGE);
  localparam logic [DirW-1:0]    DirNum     = DirW'(vcfc_pkg::NUM_DIRS);
  localparam logic [DirW-1:0]    DirLast    = DirW'(vcfc_pkg::NUM_DIRS - 1);

  function automatic logic [TotalW-1:0] popcount(input logic [MaskW-1:0] v);
    logic [TotalW-1:0] c;
    c = '0;
    for (int i = 0; i < MaskW; i++) begin
      c = c + {{(TotalW-1){1'b0}}, v[i]};
    end
    return c;
  endfunction

  logic [ClassW-1:0] cell_mem [CellDepth];
  logic [ClassW-1:0] lay_mem  [LayDepth];

  vcfc_pkg::req_t    req_q;
  logic [CeW-1:0]    chunk_edge_q;
  logic [MaskW-1:0]  nb_present_q;
  logic [ClrW-1:0]   clr_cnt_q;
  logic [ClassW-1:0] cell_rd_q, lay_rd_q;
  logic              pend_q, pend_center_q, pend_forced_q, pend_layer_q;
  logic [DirW-1:0]   pend_dir_q;
  logic              drawn_q;
  logic [MaskW-1:0]  mask_q;
  logic [FaceW-1:0]  face_cnt_q;
  logic              res_valid_q;
  vcfc_pkg::res_t    res_q;

  logic [EdgeW-1:0]  edge_len, edge_last;
  logic [EdgeW-1:0]  p [3];
  logic [EdgeW-1:0]  q [3];
  logic              in_chunk;
  logic [DirW-1:0]   dir_sel;
  logic [1:0]        axis;
  logic              at_edge, on_layer;
  logic [EdgeW-1:0]  lay_a, lay_b;
  logic [CellAW-1:0] p_addr, q_addr, cell_addr;
  logic [LayAW-1:0]  lay_addr;
  logic              cell_we, lay_we;
  logic [ClassW-1:0] wr_data;
  logic [ClassW-1:0] nb_class;
  logic              vis;
  logic [MaskW-1:0]  eval_bits, mask_full;
  logic [TotalW-1:0] total;
  logic [FaceW-1:0]  face_sum;

  always_comb begin
    if (chunk_edge_q == '0) begin
      edge_len = EdgeW'(1);
    end else if ({1'b0, chunk_edge_q} > MaxEdgeL) begin
      edge_len = MaxEdgeL;
    end else begin
      edge_len = {1'b0, chunk_edge_q};
    end
    edge_last = edge_len - 1'b1;
  end

  always_comb begin
    p[0] = {2'b00, req_q.cell_x};
    p[1] = {2'b00, req_q.cell_y};
    p[2] = {2'b00, req_q.cell_z};
    in_chunk = (p[0] < edge_len) && (p[1] < edge_len) && (p[2] < edge_len);
  end

  // The query direction drives the layer and neighbor address in the direction-read state,
  // the item's side does so for a neighbor-layer write.
  assign dir_sel = cmd_i.rd_dir ? cmd_i.dir : req_q.side;
  assign axis    = dir_sel[2:1];

  always_comb begin
    at_edge  = 1'b0;
    on_layer = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q[i] = p[i];
      if (axis == 2'(i)) begin
        q[i]     = dir_sel[0] ? (p[i] - 1'b1) : (p[i] + 1'b1);
        at_edge  = dir_sel[0] ? (p[i] == '0) : (p[i] == edge_last);
        on_layer = dir_sel[0] ? (p[i] == edge_last) : (p[i] == '0);
      end
    end
    lay_a = (axis == 2'd0) ? p[1] : p[0];
    lay_b = (axis == 2'd2) ? p[1] : p[2];
  end

  assign p_addr = {p[0][CW-1:0], p[1][CW-1:0], p[2][CW-1:0]};
  assign q_addr = {q[0][CW-1:0], q[1][CW-1:0], q[2][CW-1:0]};

  always_comb begin
    if (cmd_i.clear) begin
      cell_addr = clr_cnt_q[CellAW-1:0];
      lay_addr  = clr_cnt_q[LayAW-1:0];
      wr_data   = '0;
    end else begin
      cell_addr = cmd_i.rd_dir ? q_addr : p_addr;
      lay_addr  = {dir_sel, lay_a[CW-1:0], lay_b[CW-1:0]};
      wr_data   = req_q.cell_class;
    end
    cell_we = (cmd_i.clear && ({1'b0, clr_cnt_q} < CellDepthL)) ||
              (cmd_i.exec && (req_q.req_type == vcfc_pkg::REQ_WR_OWN) && in_chunk);
    lay_we  = (cmd_i.clear && ({1'b0, clr_cnt_q} < LayDepthL)) ||
              (cmd_i.exec && (req_q.req_type == vcfc_pkg::REQ_WR_NB) && in_chunk &&
               (req_q.side < DirNum) && on_layer);
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_addr] <= wr_data;
    end
    cell_rd_q <= cell_mem[cell_addr];
  end

  always_ff @(posedge clk_i) begin
    if (lay_we) begin
      lay_mem[lay_addr] <= wr_data;
    end
    lay_rd_q <= lay_mem[lay_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_edge_q <= vcfc_pkg::CHUNK_EDGE_RST;
      nb_present_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vcfc_pkg::CFG_CHUNK_EDGE:       chunk_edge_q <= cfg_data_i[CeW-1:0];
        vcfc_pkg::CFG_NEIGHBOR_PRESENT: nb_present_q <= cfg_data_i[MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == ClrLastL);

  // Evaluate the word read in the previous cycle.
  assign nb_class = pend_layer_q ? lay_rd_q : cell_rd_q;
  assign vis      = pend_forced_q || !nb_class[1];

  always_comb begin
    eval_bits = '0;
    if (pend_q && !pend_center_q && vis) begin
      eval_bits[pend_dir_q] = 1'b1;
    end
    mask_full = (mask_q | eval_bits) & {MaskW{drawn_q}};
    total     = popcount(mask_full);
    face_sum  = face_cnt_q + FaceW'(total);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q        <= 1'b0;
      pend_center_q <= 1'b0;
      pend_forced_q <= 1'b0;
      pend_layer_q  <= 1'b0;
      pend_dir_q    <= '0;
    end else begin
      pend_q        <= cmd_i.rd_center || cmd_i.rd_dir;
      pend_center_q <= cmd_i.rd_center;
      pend_forced_q <= cmd_i.rd_dir && at_edge && !nb_present_q[cmd_i.dir];
      pend_layer_q  <= cmd_i.rd_dir && at_edge;
      pend_dir_q    <= cmd_i.dir;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_center) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_q | eval_bits;
    end
    if (pend_q && pend_center_q) begin
      drawn_q <= in_chunk && (cell_rd_q != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_cnt_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.finish;
      if (cmd_i.exec && (req_q.req_type == vcfc_pkg::REQ_RESTART)) begin
        face_cnt_q <= '0;
      end else if (cmd_i.finish) begin
        face_cnt_q <= (face_sum > vcfc_pkg::FACE_CAP) ? vcfc_pkg::FACE_CAP : face_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.face_mask  <= mask_full;
      res_q.face_base  <= face_cnt_q;
      res_q.face_total <= total;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `VCFC_ASSERT(a_res_pulse, res_valid_q |=> !res_valid_q, "result strobe lasted two cycles")
  `VCFC_ASSERT(a_finish_pending, cmd_i.finish |-> (pend_q && !pend_center_q && (pend_dir_q == DirLast)), "finish without last direction pending")
  `VCFC_ASSERT_ALWAYS(a_face_cap, !rst_ni || (face_cnt_q <= vcfc_pkg::FACE_CAP), "face counter above cap")

endmodule

`default_nettype wire

FILE: src/voxel_chunk_face_culler.sv
// A write or restart keeps busy high for the execute state after acceptance. A query keeps
// busy high through the center read, six neighbor reads on the single-port stores and the
// finish state; its registered result strobes as busy falls, so a new word is taken only
// once the last query is done. After reset both stores are cleared one entry a cycle, 4096
// entries at MAX_EDGE 16 (the larger of 2^(3*ceil(log2 MAX_EDGE)) and 6*2^(2*ceil(log2
// MAX_EDGE))); busy is high meanwhile and configuration writes are taken. No result stalls.
`timescale 1ns / 1ps
`default_nettype none

module voxel_chunk_face_culler #(
  parameter int unsigned MAX_EDGE = vcfc_pkg::MAX_EDGE_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire vcfc_pkg::req_t                  req_i,
  output logic                                 res_valid_o,
  output vcfc_pkg::res_t                       res_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [vcfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [vcfc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  vcfc_pkg::cmd_t cmd;
  vcfc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  vcfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  vcfc_datapath #(
    .MAX_EDGE (MAX_EDGE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
